### design/assert_macros.svh
// Assertion shorthands shared by the factoriser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/pftd_pkg.sv
package pftd_pkg;

    localparam int PRIME_W     = 31;
    localparam int EXP_W       = 5;
    localparam int CNT_W       = 4;
    localparam int MAX_RESULTS = 9;

    localparam logic [EXP_W-1:0] EXP_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RESULTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_EVAL,
        S_FINISH,
        S_NONE
    } t_state;

    typedef struct packed {
        logic load;         // take a new value, reset the search
        logic start;        // divide remainder by current divisor
        logic take_quot;    // remainder <= quotient, count one more, divide again
        logic next_cand;    // step to the next candidate divisor and divide
        logic capture;      // record a factor, pushing the held one out
        logic cap_sel_rem;  // factor is the leftover remainder, exponent one
        logic out_final;    // send the held factor as the closing beat
        logic out_none;     // send the no-factor beat
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic below_two;    // remainder below two
        logic stop;         // divisor above quotient
        logic exact;        // division left no remainder
        logic first;        // first division by this divisor
        logic r_gt1;        // remainder above one
        logic cap_blocked;  // capture would need the output slot, which is full
        logic out_free;
    } t_dp_sts;

endpackage

### design/pftd_if.sv
interface pftd_in_if #(
    parameter int VALUE_BITS = 31
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface pftd_out_if;
    logic                         valid;
    logic                         ready;
    logic [pftd_pkg::PRIME_W-1:0] prime;
    logic [pftd_pkg::EXP_W-1:0]   exponent;
    logic                         no_factor;
    logic                         last;

    modport source (output valid, output prime, output exponent, output no_factor,
                    output last, input ready);
    modport sink   (input valid, input prime, input exponent, input no_factor,
                    input last, output ready);
endinterface

### design/pftd_datapath.sv
`include "assert_macros.svh"

module pftd_datapath #(
    parameter int VALUE_BITS = 31
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pftd_pkg::t_dp_cmd            i_cmd,
    output pftd_pkg::t_dp_sts            o_sts,
    input  logic [VALUE_BITS-1:0]        i_value,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [pftd_pkg::PRIME_W-1:0] o_prime,
    output logic [pftd_pkg::EXP_W-1:0]   o_exponent,
    output logic                         o_no_factor,
    output logic                         o_last
);
    import pftd_pkg::*;

    localparam int CW = $clog2(VALUE_BITS + 1);
    localparam int WW = VALUE_BITS + PRIME_W;
    localparam logic [VALUE_BITS-1:0] TWO   = VALUE_BITS'(2);
    localparam logic [VALUE_BITS-1:0] THREE = VALUE_BITS'(3);
    localparam logic [CW-1:0]         STEPS = CW'(VALUE_BITS);

    logic [VALUE_BITS-1:0] r_rem;
    logic [VALUE_BITS-1:0] r_div;
    logic [EXP_W-1:0]      r_mult;
    logic                  r_first;
    logic [VALUE_BITS-1:0] r_dq;     // dividend shifting out, quotient shifting in
    logic [VALUE_BITS-1:0] r_dr;     // partial remainder
    logic [CW-1:0]         r_dcnt;
    logic [CNT_W-1:0]      r_count;
    logic [VALUE_BITS-1:0] r_pend_p;
    logic [EXP_W-1:0]      r_pend_e;
    logic                  r_out_valid;
    logic [PRIME_W-1:0]    r_out_prime;
    logic [EXP_W-1:0]      r_out_exp;
    logic                  r_out_nf;
    logic                  r_out_last;

    logic [VALUE_BITS:0]   div_sub;
    logic [VALUE_BITS:0]   div_diff;
    logic                  div_ge;
    logic [VALUE_BITS-1:0] div_next;
    logic [EXP_W-1:0]      mult_inc;
    logic [VALUE_BITS-1:0] cap_p;
    logic [EXP_W-1:0]      cap_e;
    logic [WW-1:0]         pend_wide;
    logic                  out_free;
    logic                  push;
    logic                  div_launch;

    assign div_sub    = {r_dr, r_dq[VALUE_BITS-1]};
    assign div_ge     = div_sub >= {1'b0, r_div};
    assign div_diff   = div_sub - {1'b0, r_div};
    assign div_next   = (r_div == TWO) ? THREE : r_div + TWO;
    assign mult_inc   = (r_mult == EXP_MAX) ? r_mult : r_mult + EXP_W'(1);
    assign cap_p      = i_cmd.cap_sel_rem ? r_rem : r_div;
    assign cap_e      = i_cmd.cap_sel_rem ? EXP_W'(1) : r_mult;
    assign pend_wide  = {{PRIME_W{1'b0}}, r_pend_p};
    assign out_free   = !r_out_valid || i_out_ready;
    assign push       = i_cmd.capture && (r_count != '0) && (r_count != CNT_MAX);
    assign div_launch = i_cmd.start || i_cmd.take_quot || i_cmd.next_cand;

    always_comb begin
        o_sts             = '0;
        o_sts.div_busy    = r_dcnt != '0;
        o_sts.below_two   = r_rem < TWO;
        o_sts.stop        = r_div > r_dq;
        o_sts.exact       = r_dr == '0;
        o_sts.first       = r_first;
        o_sts.r_gt1       = r_rem > VALUE_BITS'(1);
        o_sts.cap_blocked = (r_count != '0) && (r_count != CNT_MAX) && !out_free;
        o_sts.out_free    = out_free;
    end

    // search registers and the shared restoring divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt  <= '0;
            r_count <= '0;
            r_first <= 1'b1;
        end else begin
            if (i_cmd.load) begin
                r_rem   <= i_value;
                r_div   <= TWO;
                r_mult  <= '0;
                r_first <= 1'b1;
                r_count <= '0;
            end
            if (i_cmd.start) begin
                r_dq   <= r_rem;
                r_dr   <= '0;
                r_dcnt <= STEPS;
            end else if (i_cmd.take_quot) begin
                r_rem   <= r_dq;
                r_mult  <= mult_inc;
                r_first <= 1'b0;
                r_dr    <= '0;
                r_dcnt  <= STEPS;
            end else if (i_cmd.next_cand) begin
                r_div   <= div_next;
                r_mult  <= '0;
                r_first <= 1'b1;
                r_dq    <= r_rem;
                r_dr    <= '0;
                r_dcnt  <= STEPS;
            end else if (r_dcnt != '0) begin
                r_dq   <= {r_dq[VALUE_BITS-2:0], div_ge};
                r_dr   <= div_ge ? div_diff[VALUE_BITS-1:0] : div_sub[VALUE_BITS-1:0];
                r_dcnt <= r_dcnt - CW'(1);
            end
            // hold one factor back so the closing beat can be marked; drop beyond the cap
            if (i_cmd.capture && (r_count != CNT_MAX)) begin
                r_pend_p <= cap_p;
                r_pend_e <= cap_e;
                r_count  <= r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (push || i_cmd.out_final) begin
                r_out_valid <= 1'b1;
                r_out_prime <= pend_wide[PRIME_W-1:0];
                r_out_exp   <= r_pend_e;
                r_out_nf    <= 1'b0;
                r_out_last  <= i_cmd.out_final;
            end else if (i_cmd.out_none) begin
                r_out_valid <= 1'b1;
                r_out_prime <= '0;
                r_out_exp   <= '0;
                r_out_nf    <= 1'b1;
                r_out_last  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_prime     = r_out_prime;
    assign o_exponent  = r_out_exp;
    assign o_no_factor = r_out_nf;
    assign o_last      = r_out_last;

    `ASSERT_ALWAYS(a_count_cap, i_clk, i_rst_n, r_count <= CNT_MAX)
    `ASSERT_NEXT(a_div_runs, i_clk, i_rst_n, div_launch, r_dcnt == STEPS)
    `ASSERT_IMPL(a_final_has_factor, i_clk, i_rst_n, i_cmd.out_final, r_count != '0)

endmodule

### design/pftd_ctrl.sv
`include "assert_macros.svh"

module pftd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pftd_pkg::t_dp_sts i_sts,
    output pftd_pkg::t_dp_cmd o_cmd
);
    import pftd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.below_two) begin
                    n_state = S_NONE;
                end else begin
                    o_cmd.start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.first && i_sts.stop) begin
                    // search over: leftover remainder above one is prime
                    if (!i_sts.r_gt1) begin
                        n_state = S_FINISH;
                    end else if (!i_sts.cap_blocked) begin
                        o_cmd.capture     = 1'b1;
                        o_cmd.cap_sel_rem = 1'b1;
                        n_state           = S_FINISH;
                    end
                end else if (i_sts.exact) begin
                    o_cmd.take_quot = 1'b1;
                    n_state         = S_DIV;
                end else if (i_sts.first) begin
                    o_cmd.next_cand = 1'b1;
                    n_state         = S_DIV;
                end else if (!i_sts.cap_blocked) begin
                    o_cmd.capture   = 1'b1;
                    o_cmd.next_cand = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_final = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_NONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_none = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `ASSERT_IMPL(a_eval_div_idle, i_clk, i_rst_n, r_state == S_EVAL, !i_sts.div_busy)
    `ASSERT_NEXT(a_accept_checks, i_clk, i_rst_n, o_in_ready && i_in_valid, r_state == S_CHECK)
    `ASSERT_IMPL(a_ready_only_idle, i_clk, i_rst_n, o_in_ready, r_state == S_IDLE)

endmodule

### design/prime_factorizer_trial_division.sv
// Channel  Dir  Payload                               Ends
// i_in     in   value[VALUE_BITS-1:0]                 valid / ready
// o_out    out  prime[30:0] exponent[4:0] no_factor   valid / ready
//               last
//
// One value at a time; i_in.ready is high only while no value is in work.
// Each trial division runs on one bit-serial divider.
// Values below two are answered with a single no-factor beat.
// Reset is synchronous, active low, and clears control state only.
// A stalled o_out holds its beat; the search pauses while a factor waits for it.

module prime_factorizer_trial_division #(
    parameter int VALUE_BITS = 31
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pftd_in_if.sink           i_in,
    pftd_out_if.source        o_out
);
    import pftd_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    pftd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    pftd_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_value     (i_in.value),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_prime     (o_out.prime),
        .o_exponent  (o_out.exponent),
        .o_no_factor (o_out.no_factor),
        .o_last      (o_out.last)
    );

endmodule
